// ===== src/color_aware_byte_fifo_admission_defines.svh =====
// Assertion macros used by the checker file.
`ifndef COLOR_AWARE_BYTE_FIFO_ADMISSION_DEFINES_SVH
`define COLOR_AWARE_BYTE_FIFO_ADMISSION_DEFINES_SVH

// Checked at every clock edge, reset included.
`define CABF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("cabf check failed");

// Checked only while reset is released.
`define CABF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cabf check failed");

`endif

// ===== src/cabf_pkg.sv =====
`default_nettype none
package cabf_pkg;

  localparam int unsigned QUEUE_SLOTS = 256;
  localparam int unsigned IDX_W       = $clog2(QUEUE_SLOTS);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned MAX_VICTIMS = 63;
  localparam int unsigned VIC_W       = $clog2(MAX_VICTIMS + 1);
  localparam int unsigned EVIC_W      = 22;
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  // Result event codes.
  localparam logic [2:0] EV_ENQUEUED = 3'd0;
  localparam logic [2:0] EV_DROPPED  = 3'd1;
  localparam logic [2:0] EV_EVICTED  = 3'd2;
  localparam logic [2:0] EV_DEQUEUED = 3'd3;
  localparam logic [2:0] EV_EMPTY    = 3'd4;

  // Request commands.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Network layer kinds.
  localparam logic [1:0] L3_IPV4 = 2'd1;
  localparam logic [1:0] L3_IPV6 = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_BYTE_LIMIT    = 3'd0;
  localparam logic [2:0] REG_QUEUE_CONTROL = 3'd1;
  localparam logic [2:0] REG_ROUND_UNIT    = 3'd2;
  localparam logic [2:0] REG_CONTROL_MODE  = 3'd3;

  localparam logic [31:0] BYTE_LIMIT_RST = 32'd1500000;
  localparam logic [15:0] ROUND_UNIT_RST = 16'd1500;
  localparam logic [7:0]  MARK_BIT       = 8'h04;

  typedef struct packed {
    logic load;      // latch the accepted request
    logic rd_en;     // read the descriptor memories
    logic rd_victim; // read at the marked tail instead of the queue head
    logic div_step;
    logic thr;
    logic decide;
    logic evict;
    logic finish;
    logic deq;
    logic empty;
  } cabf_cmd_t;

  typedef struct packed {
    logic mode1;
    logic pkt_zero;
    logic evict_path;
    logic evict_more;
    logic out_room;
  } cabf_sts_t;

endpackage
`default_nettype wire

// ===== src/cabf_ctrl.sv =====
`default_nettype none
module cabf_ctrl import cabf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_stall,
  input  cabf_sts_t sts,
  output cabf_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DIV    = 9'b000000010,
    S_THR    = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_VCHK   = 9'b000010000,
    S_VEXE   = 9'b000100000,
    S_ADMIT  = 9'b001000000,
    S_DEQ    = 9'b010000000,
    S_EMPTY  = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [VIC_W-1:0]     vic_r;
  logic                 accept;
  logic                 more_victims;

  assign accept       = (state_r == S_IDLE) && in_valid;
  assign in_stall     = (state_r != S_IDLE);
  assign more_victims = sts.evict_more && (vic_r < VIC_W'(MAX_VICTIMS));

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.rd_en = 1'b1;
        cmd.load  = in_valid;
        if (in_valid) begin
          if (in_cmd == CMD_DEQ) begin
            state_nxt = sts.pkt_zero ? S_EMPTY : S_DEQ;
          end else begin
            state_nxt = sts.mode1 ? S_DIV : S_THR;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_THR;
        end
      end
      S_THR: begin
        cmd.thr   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.evict_path ? S_VCHK : S_ADMIT;
      end
      S_VCHK: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_victim = 1'b1;
        state_nxt     = more_victims ? S_VEXE : S_ADMIT;
      end
      S_VEXE: begin
        cmd.evict = sts.out_room;
        if (sts.out_room) begin
          state_nxt = S_VCHK;
        end
      end
      S_ADMIT: begin
        cmd.finish = sts.out_room;
        if (sts.out_room) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEQ: begin
        cmd.deq = sts.out_room;
        if (sts.out_room) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd.empty = sts.out_room;
        if (sts.out_room) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
      vic_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        div_cnt_r <= '0;
        vic_r     <= '0;
      end else begin
        if (cmd.div_step) begin
          div_cnt_r <= div_cnt_r + 1'b1;
        end
        if (cmd.evict) begin
          vic_r <= vic_r + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cabf_dp.sv =====
`default_nettype none
module cabf_dp import cabf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [15:0] in_pkt_tag,
  input  logic [15:0] in_pkt_len,
  input  logic [1:0]  in_l3_kind,
  input  logic [7:0]  in_ds_byte,
  input  logic [31:0] in_parent_deficit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_tag,
  output logic [15:0] out_len,
  output logic        out_marked,
  output logic        out_last,
  input  cabf_cmd_t   cmd,
  output cabf_sts_t   sts
);

  // Configuration.
  logic [31:0] byte_limit_r, queue_ctrl_r;
  logic [15:0] round_unit_r;
  logic        ctrl_mode_r;

  // Latched request and decision.
  logic [15:0] tag_r, len_r;
  logic        mk_r;
  logic [31:0] deficit_r, dvd_r, thr_r;
  logic [15:0] rem_r;
  logic        admit_r;

  // Queue state.
  logic [IDX_W-1:0]  free_head_r, fhead_r, ftail_r, mhead_r, mtail_r;
  logic [31:0]       backlog_r;
  logic [CNT_W-1:0]  pcount_r, mcount_r;
  logic [EVIC_W-1:0] evicted_r;

  // Descriptor memories.
  logic [32:0]      slot_mem  [QUEUE_SLOTS];
  logic [IDX_W-1:0] fnext_mem [QUEUE_SLOTS];
  logic [IDX_W-1:0] fprev_mem [QUEUE_SLOTS];
  logic [IDX_W-1:0] mnext_mem [QUEUE_SLOTS];
  logic [IDX_W-1:0] mprev_mem [QUEUE_SLOTS];
  logic [IDX_W-1:0] flink_mem [QUEUE_SLOTS];
  logic [QUEUE_SLOTS-1:0] flink_vld_r;

  logic [32:0]      slot_q;
  logic [IDX_W-1:0] fnext_q, fprev_q, mnext_q, mprev_q, flink_q;

  logic [15:0] q_tag, q_len;
  logic        q_mk;
  assign q_tag = slot_q[32:17];
  assign q_len = slot_q[16:1];
  assign q_mk  = slot_q[0];

  logic [IDX_W-1:0] rd_a;
  assign rd_a = cmd.rd_victim ? mtail_r : fhead_r;

  logic        in_mk;
  logic [15:0] unit_eff;
  logic [16:0] div_t, div_sub;
  logic [31:0] rounded;
  logic [32:0] need;
  logic        limit_ok, over;
  logic        fifo_mid;
  logic        release_en;
  logic [IDX_W-1:0] rel_slot;
  logic        emit;

  assign in_mk = ((in_l3_kind == L3_IPV4) || (in_l3_kind == L3_IPV6)) &&
                 ((in_ds_byte & (MARK_BIT << 2)) != 8'd0);
  assign unit_eff = (round_unit_r == 16'd0) ? 16'd1 : round_unit_r;
  assign div_t    = {rem_r, dvd_r[31]};
  assign div_sub  = div_t - {1'b0, unit_eff};
  assign rounded  = (rem_r != 16'd0) ? deficit_r + {16'd0, unit_eff - rem_r} : deficit_r;
  assign need     = {1'b0, backlog_r} + {17'd0, len_r};
  assign limit_ok = (byte_limit_r != 32'd0) && (need <= {1'b0, byte_limit_r}) &&
                    !pcount_r[CNT_W-1];
  assign over     = need > {1'b0, thr_r};
  // The victim sits strictly inside the queue: its neighbors are relinked.
  assign fifo_mid = (pcount_r > CNT_W'(1)) && (mtail_r != fhead_r) && (mtail_r != ftail_r);
  assign release_en = cmd.evict || cmd.deq;
  assign rel_slot   = cmd.evict ? mtail_r : fhead_r;
  assign emit       = cmd.evict || cmd.finish || cmd.deq || cmd.empty;

  assign sts.mode1      = ctrl_mode_r;
  assign sts.pkt_zero   = (pcount_r == '0);
  assign sts.evict_path = limit_ok && over && !mk_r;
  assign sts.evict_more = (evicted_r < {{(EVIC_W-16){1'b0}}, len_r}) &&
                          (mcount_r != '0) && ctrl_mode_r;
  assign sts.out_room   = !out_valid || !out_stall;

  // Memory reads, registered.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      slot_q  <= slot_mem[rd_a];
      fnext_q <= fnext_mem[rd_a];
      fprev_q <= fprev_mem[rd_a];
      mnext_q <= mnext_mem[rd_a];
      mprev_q <= mprev_mem[rd_a];
    end
    // A free link never written still holds its place in the initial chain.
    flink_q <= flink_vld_r[free_head_r] ? flink_mem[free_head_r] : free_head_r + 1'b1;
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (cmd.finish && admit_r) begin
      slot_mem[free_head_r] <= {tag_r, len_r, mk_r};
      if (pcount_r != '0) begin
        fnext_mem[ftail_r]     <= free_head_r;
        fprev_mem[free_head_r] <= ftail_r;
      end
      if (mk_r && (mcount_r != '0)) begin
        mnext_mem[mtail_r]     <= free_head_r;
        mprev_mem[free_head_r] <= mtail_r;
      end
    end
    if (cmd.evict && fifo_mid) begin
      fnext_mem[fprev_q] <= fnext_q;
      fprev_mem[fnext_q] <= fprev_q;
    end
    if (release_en) begin
      flink_mem[rel_slot] <= free_head_r;
    end
  end

  // Request latch and rounding divider.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_r     <= in_pkt_tag;
      len_r     <= in_pkt_len;
      mk_r      <= in_mk;
      deficit_r <= in_parent_deficit;
      dvd_r     <= in_parent_deficit;
      rem_r     <= '0;
      evicted_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_sub[16] ? div_t[15:0] : div_sub[15:0];
      dvd_r <= {dvd_r[30:0], 1'b0};
    end
    if (cmd.thr) begin
      thr_r <= ctrl_mode_r ? queue_ctrl_r + rounded : queue_ctrl_r;
    end
    if (cmd.decide) begin
      admit_r <= limit_ok && (!over || !mk_r);
    end
    if (cmd.evict) begin
      evicted_r <= evicted_r + {{(EVIC_W-16){1'b0}}, q_len};
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.evict) begin
      out_event_res <= EV_EVICTED;
      out_tag       <= q_tag;
      out_len       <= q_len;
      out_marked    <= q_mk;
      out_last      <= 1'b0;
    end else if (cmd.deq) begin
      out_event_res <= EV_DEQUEUED;
      out_tag       <= q_tag;
      out_len       <= q_len;
      out_marked    <= q_mk;
      out_last      <= 1'b1;
    end else if (cmd.empty) begin
      out_event_res <= EV_EMPTY;
      out_tag       <= '0;
      out_len       <= '0;
      out_marked    <= 1'b0;
      out_last      <= 1'b1;
    end else if (cmd.finish) begin
      out_event_res <= admit_r ? EV_ENQUEUED : EV_DROPPED;
      out_tag       <= tag_r;
      out_len       <= len_r;
      out_marked    <= mk_r;
      out_last      <= 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= BYTE_LIMIT_RST;
      queue_ctrl_r <= '0;
      round_unit_r <= ROUND_UNIT_RST;
      ctrl_mode_r  <= 1'b0;
      free_head_r  <= '0;
      fhead_r      <= '0;
      ftail_r      <= '0;
      mhead_r      <= '0;
      mtail_r      <= '0;
      backlog_r    <= '0;
      pcount_r     <= '0;
      mcount_r     <= '0;
      flink_vld_r  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BYTE_LIMIT:    byte_limit_r <= cfg_data;
          REG_QUEUE_CONTROL: queue_ctrl_r <= cfg_data;
          REG_ROUND_UNIT:    round_unit_r <= cfg_data[15:0];
          REG_CONTROL_MODE:  ctrl_mode_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (release_en) begin
        flink_vld_r[rel_slot] <= 1'b1;
        free_head_r           <= rel_slot;
      end

      if (cmd.evict) begin
        // The victim is the newest marked packet.
        if (mcount_r <= CNT_W'(1)) begin
          mhead_r <= '0;
          mtail_r <= '0;
        end else if (mtail_r == mhead_r) begin
          mhead_r <= mnext_q;
        end else begin
          mtail_r <= mprev_q;
        end
        if (mcount_r != '0) begin
          mcount_r <= mcount_r - 1'b1;
        end
        if (pcount_r <= CNT_W'(1)) begin
          fhead_r <= '0;
          ftail_r <= '0;
        end else if (mtail_r == fhead_r) begin
          fhead_r <= fnext_q;
        end else if (mtail_r == ftail_r) begin
          ftail_r <= fprev_q;
        end
        if (pcount_r != '0) begin
          pcount_r <= pcount_r - 1'b1;
        end
        backlog_r <= backlog_r - {16'd0, q_len};
      end

      if (cmd.deq) begin
        if (pcount_r <= CNT_W'(1)) begin
          fhead_r <= '0;
          ftail_r <= '0;
        end else begin
          fhead_r <= fnext_q;
        end
        pcount_r  <= pcount_r - 1'b1;
        backlog_r <= backlog_r - {16'd0, q_len};
        if (q_mk && (mcount_r != '0) && (mhead_r == fhead_r)) begin
          if (mcount_r <= CNT_W'(1)) begin
            mhead_r <= '0;
            mtail_r <= '0;
          end else begin
            mhead_r <= mnext_q;
          end
          mcount_r <= mcount_r - 1'b1;
        end
      end

      if (cmd.finish && admit_r) begin
        free_head_r <= flink_q;
        if (pcount_r == '0) begin
          fhead_r <= free_head_r;
        end
        ftail_r   <= free_head_r;
        pcount_r  <= pcount_r + 1'b1;
        backlog_r <= backlog_r + {16'd0, len_r};
        if (mk_r) begin
          if (mcount_r == '0) begin
            mhead_r <= free_head_r;
          end
          mtail_r  <= free_head_r;
          mcount_r <= mcount_r + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/color_aware_byte_fifo_admission.sv =====
// Channel  | Ports                                   | Moves
// request  | in_valid, in_stall, in_cmd .. in_parent | one enqueue or dequeue request
// result   | out_valid, out_stall, out_event_res ..  | one event, out_last on the final
// config   | cfg_we, cfg_index, cfg_data             | one register write per edge
// A dequeue, empty or not, is accepted and then written to the result register.
// An enqueue passes the threshold and decision steps, after the bit-serial deficit rounding in
// mode one. An unmarked arrival above the threshold (within the byte limit) adds the victim
// check, plus a memory read and an unlink for each evicted marked packet.
// Requests are handled one at a time; the result register lets a new request in
// while the last event still waits. Stalls on the result side hold the sequencer.
// Reset is synchronous and active low; the free chain needs no clearing pass.
`default_nettype none
module color_aware_byte_fifo_admission import cabf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_pkt_tag,
  input  logic [15:0] in_pkt_len,
  input  logic [1:0]  in_l3_kind,
  input  logic [7:0]  in_ds_byte,
  input  logic [31:0] in_parent_deficit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_tag,
  output logic [15:0] out_len,
  output logic        out_marked,
  output logic        out_last
);

  cabf_cmd_t cmd;
  cabf_sts_t sts;

  cabf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cabf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_pkt_tag        (in_pkt_tag),
    .in_pkt_len        (in_pkt_len),
    .in_l3_kind        (in_l3_kind),
    .in_ds_byte        (in_ds_byte),
    .in_parent_deficit (in_parent_deficit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_tag           (out_tag),
    .out_len           (out_len),
    .out_marked        (out_marked),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
`default_nettype wire

// ===== src/cabf_checker.sv =====
`default_nettype none
`include "color_aware_byte_fifo_admission_defines.svh"
module cabf_checker import cabf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_res,
  input logic [15:0] out_len,
  input logic        out_last
);

  `CABF_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  `CABF_ASSERT(a_out_holds, clk, rst_n, out_valid && out_stall |=> out_valid)
  `CABF_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `CABF_ASSERT(a_busy_until_last, clk, rst_n, out_valid && !out_last |-> in_stall)
  `CABF_ASSERT(a_empty_zero_len, clk, rst_n, out_valid && (out_event_res == EV_EMPTY) |-> (out_len == 16'd0) && out_last)

endmodule

bind color_aware_byte_fifo_admission cabf_checker u_cabf_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_color_aware_byte_fifo_admission.sv =====
`timescale 1ns / 100ps
module tb_color_aware_byte_fifo_admission;
  import cabf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] L3_OTHER = 2'd0;
  localparam logic [1:0] L3_UNLISTED = 2'd3;

  typedef struct {
    logic        cmd;
    logic [15:0] tag;
    logic [15:0] len;
    logic [1:0]  kind;
    logic [7:0]  ds;
    logic [31:0] deficit;
  } request_t;

  typedef struct {
    logic [2:0]  ev;
    logic [15:0] tag;
    logic [15:0] len;
    logic        mk;
    logic        last;
  } event_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, in_cmd;
  logic [15:0] in_pkt_tag, in_pkt_len;
  logic [1:0] in_l3_kind;
  logic [7:0] in_ds_byte;
  logic [31:0] in_parent_deficit;
  logic out_valid, out_stall;
  logic [2:0] out_event_res;
  logic [15:0] out_tag, out_len;
  logic out_marked, out_last;

  color_aware_byte_fifo_admission dut (.*);

  request_t pending_reqs[$];
  event_t   expected_events[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit just_taken = 0;
  bit quiet = 0;
  bit hold_send = 0;
  bit long_hold_req = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  // Shadow copy of the queue state.
  logic [31:0] byte_limit_q, queue_control_q;
  logic [15:0] round_unit_q;
  logic        mode_q;
  logic [15:0] s_tag[256];
  logic [15:0] s_len[256];
  logic        s_mk[256];
  logic [7:0]  f_nxt[256], f_prv[256], m_nxt[256], m_prv[256], free_nxt[256];
  logic [7:0]  free_top, f_head, f_tail, m_head, m_tail;
  logic [31:0] backlog;
  int unsigned pkt_cnt, mk_cnt;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_shadow();
    byte_limit_q = BYTE_LIMIT_RST;
    queue_control_q = 0;
    round_unit_q = ROUND_UNIT_RST;
    mode_q = 0;
    for (int i = 0; i < 256; i++) free_nxt[i] = 8'(i + 1);
    free_top = 0; f_head = 0; f_tail = 0; m_head = 0; m_tail = 0;
    backlog = 0; pkt_cnt = 0; mk_cnt = 0;
  endfunction

  function automatic void push_event(logic [2:0] ev, logic [15:0] tag, logic [15:0] len,
                                     logic mk);
    event_t e;
    e.ev = ev; e.tag = tag; e.len = len; e.mk = mk; e.last = 0;
    expected_events.push_back(e);
  endfunction

  function automatic void unlink_queue(logic [7:0] s);
    if (pkt_cnt <= 1) begin
      f_head = 0; f_tail = 0;
    end else if (s == f_head) begin
      f_head = f_nxt[s];
    end else if (s == f_tail) begin
      f_tail = f_prv[s];
    end else begin
      f_nxt[f_prv[s]] = f_nxt[s];
      f_prv[f_nxt[s]] = f_prv[s];
    end
    if (pkt_cnt > 0) pkt_cnt--;
  endfunction

  function automatic void unlink_marked_list(logic [7:0] s);
    if (mk_cnt <= 1) begin
      m_head = 0; m_tail = 0;
    end else if (s == m_head) begin
      m_head = m_nxt[s];
    end else if (s == m_tail) begin
      m_tail = m_prv[s];
    end else begin
      m_nxt[m_prv[s]] = m_nxt[s];
      m_prv[m_nxt[s]] = m_prv[s];
    end
    if (mk_cnt > 0) mk_cnt--;
  endfunction

  function automatic void predict_events(request_t r);
    logic [7:0] s, v;
    logic mk;
    logic [32:0] need;
    logic [31:0] thr, evicted;
    logic [63:0] unit, q;
    bit admit;
    int unsigned victims;
    admit = 0;
    if (r.cmd == CMD_DEQ) begin
      if (pkt_cnt == 0) begin
        push_event(EV_EMPTY, 0, 0, 0);
      end else begin
        s = f_head;
        unlink_queue(s);
        backlog = backlog - s_len[s];
        if (s_mk[s] && mk_cnt > 0 && m_head == s) unlink_marked_list(s);
        free_nxt[s] = free_top;
        free_top = s;
        push_event(EV_DEQUEUED, s_tag[s], s_len[s], s_mk[s]);
      end
    end else begin
      mk = (r.kind == L3_IPV4 || r.kind == L3_IPV6) && r.ds[4];
      need = {1'b0, backlog} + r.len;
      thr = queue_control_q;
      if (mode_q) begin
        unit = (round_unit_q != 0) ? 64'(round_unit_q) : 64'd1;
        q = 64'(r.deficit) / unit + ((64'(r.deficit) % unit) != 0 ? 64'd1 : 64'd0);
        thr = queue_control_q + 32'(q * unit);
      end
      if (byte_limit_q != 0 && need <= {1'b0, byte_limit_q} && pkt_cnt < 256) begin
        if (need > {1'b0, thr}) begin
          if (!mk) begin
            evicted = 0; victims = 0;
            while (evicted < r.len && mk_cnt > 0 && mode_q && victims < MAX_VICTIMS) begin
              v = m_tail;
              unlink_marked_list(v);
              unlink_queue(v);
              evicted = evicted + s_len[v];
              backlog = backlog - s_len[v];
              free_nxt[v] = free_top;
              free_top = v;
              victims++;
              push_event(EV_EVICTED, s_tag[v], s_len[v], s_mk[v]);
            end
            admit = 1;
          end
        end else begin
          admit = 1;
        end
      end
      if (admit) begin
        s = free_top;
        free_top = free_nxt[s];
        s_tag[s] = r.tag; s_len[s] = r.len; s_mk[s] = mk;
        if (pkt_cnt == 0) begin
          f_head = s; f_tail = s;
        end else begin
          f_nxt[f_tail] = s; f_prv[s] = f_tail; f_tail = s;
        end
        pkt_cnt++;
        backlog = backlog + r.len;
        if (mk) begin
          if (mk_cnt == 0) begin
            m_head = s; m_tail = s;
          end else begin
            m_nxt[m_tail] = s; m_prv[s] = m_tail; m_tail = s;
          end
          mk_cnt++;
        end
        push_event(EV_ENQUEUED, r.tag, r.len, mk);
      end else begin
        push_event(EV_DROPPED, r.tag, r.len, mk);
      end
    end
    expected_events[$].last = 1;
  endfunction

  // Request driver.
  always @(negedge clk) begin
    if (!(in_valid && !just_taken)) begin
      just_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 0;
      end else if (pending_reqs.size() > 0 && !hold_send) begin
        in_valid <= 1;
        in_cmd <= pending_reqs[0].cmd;
        in_pkt_tag <= pending_reqs[0].tag;
        in_pkt_len <= pending_reqs[0].len;
        in_l3_kind <= pending_reqs[0].kind;
        in_ds_byte <= pending_reqs[0].ds;
        in_parent_deficit <= pending_reqs[0].deficit;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Result-side stall generator.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      stall_left = 700;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // Acceptance, result checking and the cycle limit.
  always @(posedge clk) begin
    event_t e;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("color_aware_byte_fifo_admission test failed");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall && !just_taken) begin
        predict_events(pending_reqs.pop_front());
        just_taken = 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_res %0d tag %0d", out_event_res, out_tag);
          errors++;
        end else begin
          e = expected_events.pop_front();
          if (out_event_res !== e.ev) begin
            $error("event_res expected %0d actual %0d", e.ev, out_event_res); errors++;
          end
          if (out_tag !== e.tag) begin
            $error("out_tag expected %0d actual %0d", e.tag, out_tag); errors++;
          end
          if (out_len !== e.len) begin
            $error("out_len expected %0d actual %0d", e.len, out_len); errors++;
          end
          if (out_marked !== e.mk) begin
            $error("out_marked expected %0d actual %0d", e.mk, out_marked); errors++;
          end
          if (out_last !== e.last) begin
            $error("out_last expected %0d actual %0d", e.last, out_last); errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= data;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_BYTE_LIMIT: byte_limit_q = data;
      REG_QUEUE_CONTROL: queue_control_q = data;
      REG_ROUND_UNIT: round_unit_q = data[15:0];
      REG_CONTROL_MODE: mode_q = data[0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] lim, logic [31:0] qc, logic [15:0] ru, logic md);
    write_reg(REG_BYTE_LIMIT, lim);
    write_reg(REG_QUEUE_CONTROL, qc);
    write_reg(REG_ROUND_UNIT, {16'h0, ru});
    write_reg(REG_CONTROL_MODE, {31'h0, md});
  endtask

  task automatic enq(logic [15:0] tag, logic [15:0] len, logic [1:0] kind, logic [7:0] ds,
                     logic [31:0] deficit);
    request_t r;
    r.cmd = CMD_ENQ; r.tag = tag; r.len = len; r.kind = kind; r.ds = ds; r.deficit = deficit;
    pending_reqs.push_back(r);
  endtask

  task automatic deq();
    request_t r;
    r.cmd = CMD_DEQ; r.tag = 16'($urandom); r.len = 16'($urandom); r.kind = 2'($urandom);
    r.ds = 8'($urandom); r.deficit = $urandom;
    pending_reqs.push_back(r);
  endtask

  task automatic random_requests(int unsigned n);
    logic [15:0] len;
    logic [31:0] deficit;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        deq();
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                          : 16'($urandom_range(1, 2000));
        deficit = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5000);
        enq(16'($urandom), len, 2'($urandom), 8'($urandom), deficit);
      end
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_cmd = 0; in_pkt_tag = 0; in_pkt_len = 0; in_l3_kind = 0;
    in_ds_byte = 0; in_parent_deficit = 0; out_stall = 0;
    reset_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset settings, marking rules, field extremes, empty dequeue.
    deq();
    enq(16'hFFFF, 16'hFFFF, L3_IPV4, 8'h10, 32'hFFFF_FFFF);
    enq(16'h0000, 16'd1, L3_IPV6, 8'hFF, 32'd0);
    enq(16'h1234, 16'd100, L3_UNLISTED, 8'hFF, 32'd0);
    enq(16'h4321, 16'd200, L3_OTHER, 8'h10, 32'd0);
    enq(16'h5555, 16'd300, L3_IPV4, 8'hEF, 32'd0);
    repeat (6) deq();
    drain();

    // Directed: color threshold with eviction, and the zero byte limit.
    setup(32'd10000, 32'd3000, 16'd1000, 1'b1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    enq(16'd1, 16'd2000, L3_IPV4, 8'h10, 32'd0);
    enq(16'd2, 16'd2000, L3_IPV6, 8'h10, 32'd0);
    enq(16'd3, 16'd1500, L3_OTHER, 8'h00, 32'd0);
    enq(16'd4, 16'd9000, L3_OTHER, 8'h00, 32'd1);
    enq(16'd5, 16'd2000, L3_IPV4, 8'h10, 32'd1);
    enq(16'd6, 16'd2000, L3_IPV4, 8'h10, 32'd1001);
    repeat (3) deq();
    drain();
    write_reg(REG_BYTE_LIMIT, 32'd0);
    enq(16'd7, 16'd1, L3_OTHER, 8'h00, 32'd0);
    deq();
    drain();

    // Eviction bound: many small marked packets, then a huge unmarked one.
    setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b1);
    for (int i = 0; i < 64; i++) enq(16'(i), 16'd1, L3_IPV4, 8'h10, 32'd0);
    drain();
    write_reg(REG_QUEUE_CONTROL, 32'd0);
    enq(16'hABCD, 16'hFFFF, L3_OTHER, 8'h00, 32'd0);
    for (int i = 0; i < 3; i++) deq();
    drain();

    // Random phases across several register settings; the first one starts
    // with a long receiver hold-off so the block fills up and stalls.
    setup(32'd6000, 32'd2000, 16'd1500, 1'b1);
    long_hold_req = 1;
    random_requests(20);
    while (pending_reqs.size() > 10) @(posedge clk);
    hold_send = 1;
    while (in_valid || expected_events.size() > 0) @(posedge clk);
    hold_send = 0;
    drain();
    setup(32'd20000, 32'd0, 16'd1, 1'b1);
    random_requests(20);
    drain();
    setup(32'd1500000, 32'd4000, 16'd0, 1'b1);
    random_requests(15);
    drain();
    setup(32'd8000, 32'd3000, 16'd65535, 1'b0);
    random_requests(15);
    drain();
    quiet = 1;
    setup(32'd12000, 32'hFFFF_F000, 16'd777, 1'b1);
    random_requests(15);
    drain();

    if (errors == 0) begin
      $display("color_aware_byte_fifo_admission test passed");
    end else begin
      $display("color_aware_byte_fifo_admission test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/cabf_pkg.sv
src/cabf_ctrl.sv
src/cabf_dp.sv
src/color_aware_byte_fifo_admission.sv
src/cabf_checker.sv
tb/sv/tb_color_aware_byte_fifo_admission.sv
